>>> src/rbbe_pkg.sv
`timescale 1ns / 1ps

package rbbe_pkg;

   localparam int HALF_W = 16;
   localparam int QUAT_W = 16;
   localparam int EXT_W  = 18;

   // Largest extent code and the largest value a clamped matrix can produce.
   localparam int EXT_MAX   = (1 << EXT_W) - 1;
   localparam int EXT_BOUND = 3 * ((1 << HALF_W) - 1);

   // Half sizes and the rotation flag travel alongside the arithmetic.
   typedef struct packed {
      logic [HALF_W-1:0] hx;
      logic [HALF_W-1:0] hy;
      logic [HALF_W-1:0] hz;
      logic              rot;
   } shape_type;

endpackage

>>> src/rbbe_matrix.sv
`timescale 1ns / 1ps

module rbbe_matrix #(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  rbbe_pkg::shape_type                     in_shape,
   input  logic signed [rbbe_pkg::QUAT_W-1:0]      in_qx,
   input  logic signed [rbbe_pkg::QUAT_W-1:0]      in_qy,
   input  logic signed [rbbe_pkg::QUAT_W-1:0]      in_qz,
   input  logic signed [rbbe_pkg::QUAT_W-1:0]      in_qw,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output rbbe_pkg::shape_type                     out_shape,
   output logic [8:0][QUAT_FRAC_BITS:0]            out_mag
);
   import rbbe_pkg::*;

   localparam int F  = QUAT_FRAC_BITS;
   localparam int PW = 2 * QUAT_W;
   localparam int RW = (2 * F + 2 > PW + 3) ? 2 * F + 2 : PW + 3;

   localparam logic signed [RW-1:0] ONE_S  = RW'(1) << (2 * F);
   localparam logic [RW-1:0]        ONE_U  = RW'(1) << (2 * F);
   localparam logic [RW-1:0]        HALF_U = RW'(1) << (F - 1);
   localparam logic [F:0]           MAG_ONE = (F + 1)'(1) << F;

   // Stage 1: the nine component products.
   logic signed [PW-1:0] prod_in [9];
   logic signed [PW-1:0] prod_ff [9];
   shape_type            shape1_ff;
   logic                 v1_ff;

   // Stage 2: the nine matrix entries with 2F fraction bits.
   logic signed [RW-1:0] r_in [9];
   logic signed [RW-1:0] r_ff [9];
   shape_type            shape2_ff;
   logic                 v2_ff;

   // Stage 3: clamped and rounded entry magnitudes.
   logic [RW-1:0]        mag_abs   [9];
   logic [RW-1:0]        mag_clamp [9];
   logic [RW-1:0]        mag_round [9];
   logic [8:0][F:0]      mag_in;
   logic [8:0][F:0]      mag_ff;
   shape_type            shape3_ff;
   logic                 v3_ff;

   logic rdy1, rdy2, rdy3;
   logic mag_ok;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign out_valid = v3_ff;
   assign out_shape = shape3_ff;
   assign out_mag   = mag_ff;

   always_comb begin
      prod_in[0] = PW'(in_qx) * PW'(in_qx);
      prod_in[1] = PW'(in_qy) * PW'(in_qy);
      prod_in[2] = PW'(in_qz) * PW'(in_qz);
      prod_in[3] = PW'(in_qx) * PW'(in_qy);
      prod_in[4] = PW'(in_qx) * PW'(in_qz);
      prod_in[5] = PW'(in_qy) * PW'(in_qz);
      prod_in[6] = PW'(in_qw) * PW'(in_qx);
      prod_in[7] = PW'(in_qw) * PW'(in_qy);
      prod_in[8] = PW'(in_qw) * PW'(in_qz);
   end

   // Product order: xx yy zz xy xz yz wx wy wz. Entries are row major.
   always_comb begin
      r_in[0] = ONE_S - ((RW'(prod_ff[1]) + RW'(prod_ff[2])) <<< 1);
      r_in[1] = (RW'(prod_ff[3]) - RW'(prod_ff[8])) <<< 1;
      r_in[2] = (RW'(prod_ff[4]) + RW'(prod_ff[7])) <<< 1;
      r_in[3] = (RW'(prod_ff[3]) + RW'(prod_ff[8])) <<< 1;
      r_in[4] = ONE_S - ((RW'(prod_ff[0]) + RW'(prod_ff[2])) <<< 1);
      r_in[5] = (RW'(prod_ff[5]) - RW'(prod_ff[6])) <<< 1;
      r_in[6] = (RW'(prod_ff[4]) - RW'(prod_ff[7])) <<< 1;
      r_in[7] = (RW'(prod_ff[5]) + RW'(prod_ff[6])) <<< 1;
      r_in[8] = ONE_S - ((RW'(prod_ff[0]) + RW'(prod_ff[1])) <<< 1);
   end

   // A non-unit quaternion can push an entry past 1.0, so clamp before rounding.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         mag_abs[i]   = r_ff[i][RW-1] ? RW'(-r_ff[i]) : RW'(r_ff[i]);
         mag_clamp[i] = (mag_abs[i] > ONE_U) ? ONE_U : mag_abs[i];
         mag_round[i] = mag_clamp[i] + HALF_U;
         mag_in[i]    = mag_round[i][2*F:F];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_ff   <= prod_in;
         shape1_ff <= in_shape;
      end
      if (rdy2) begin
         r_ff      <= r_in;
         shape2_ff <= shape1_ff;
      end
      if (rdy3) begin
         mag_ff    <= mag_in;
         shape3_ff <= shape2_ff;
      end
   end

   always_comb begin
      mag_ok = 1'b1;
      for (int i = 0; i < 9; i++) begin
         if (mag_ff[i] > MAG_ONE) mag_ok = 1'b0;
      end
   end

   a_mag_clamped: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> mag_ok)
      else $error("matrix entry magnitude above 1.0");

endmodule

>>> src/rbbe_extent.sv
`timescale 1ns / 1ps

module rbbe_extent #(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  rbbe_pkg::shape_type                     in_shape,
   input  logic [8:0][QUAT_FRAC_BITS:0]            in_mag,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [2:0][rbbe_pkg::EXT_W-1:0]         out_ext
);
   import rbbe_pkg::*;

   localparam int F  = QUAT_FRAC_BITS;
   localparam int WW = F + 1 + HALF_W;
   localparam int SW = WW + 2;

   localparam logic [SW-1:0] HALF_S = SW'(1) << (F - 1);

   // Stage 4: half sizes weighted by the entry magnitudes.
   logic [WW-1:0]   wp_in [9];
   logic [WW-1:0]   wp_ff [9];
   shape_type       shape4_ff;
   logic            v4_ff;

   // Stage 5: row sums, rounding and saturation; this is the output register.
   logic [SW-1:0]               row_sum [3];
   logic [SW-1:0]               row_shift [3];
   logic [2:0][HALF_W-1:0]      id_h;
   logic [2:0][EXT_W-1:0]       ext_in;
   logic [2:0][EXT_W-1:0]       ext_ff;
   logic                        v5_ff;

   logic rdy4, rdy5;

   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   assign out_valid = v5_ff;
   assign out_ext   = ext_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         wp_in[3*r]     = WW'(in_shape.hx) * WW'(in_mag[3*r]);
         wp_in[3*r + 1] = WW'(in_shape.hy) * WW'(in_mag[3*r + 1]);
         wp_in[3*r + 2] = WW'(in_shape.hz) * WW'(in_mag[3*r + 2]);
      end
   end

   assign id_h = {shape4_ff.hz, shape4_ff.hy, shape4_ff.hx};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum[r]   = SW'(wp_ff[3*r]) + SW'(wp_ff[3*r + 1]) + SW'(wp_ff[3*r + 2])
                        + HALF_S;
         row_shift[r] = row_sum[r] >> F;
         if (!shape4_ff.rot) begin
            ext_in[r] = EXT_W'(id_h[r]);
         end else if (row_shift[r] > SW'(EXT_MAX)) begin
            ext_in[r] = EXT_W'(EXT_MAX);
         end else begin
            ext_in[r] = row_shift[r][EXT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= in_valid;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         wp_ff     <= wp_in;
         shape4_ff <= in_shape;
      end
      if (rdy5) begin
         ext_ff <= ext_in;
      end
   end

   a_ext_bound: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (ext_ff[0] <= EXT_W'(EXT_BOUND)) && (ext_ff[1] <= EXT_W'(EXT_BOUND))
                && (ext_ff[2] <= EXT_W'(EXT_BOUND)))
      else $error("extent above the clamped-matrix bound");

endmodule

>>> src/rotated_box_bound_extents_unit.sv
`timescale 1ns / 1ps

// Bounding-box half extents of a box shape, optionally rotated by a quaternion.
// Input words arrive on the req_ channel (valid/ready): three Q8.8 half sizes,
// a rotation flag and a signed quaternion with QUAT_FRAC_BITS fraction bits.
// Each input word yields exactly one rsp_ word with the three Q10.8 extents;
// with the flag clear the extents are the half sizes unchanged.
// The datapath is five register stages: component products, matrix entries,
// clamped magnitudes, weighted half sizes, and row sums into the output
// register. One word can enter every cycle, so the sustained rate is
// one word per cycle while the receiver keeps rsp_ready high.
// When the receiver stalls, the output register holds its word and each stage
// keeps its word until the one after it frees up; empty stages still fill, so
// up to five words are held before req_ready drops. Nothing is lost or repeated.
// Reset clears all stage valid bits; the block is empty and ready the cycle
// after reset is released. There are no configuration registers.
module rotated_box_bound_extents_unit #(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rbbe_pkg::HALF_W-1:0]          req_half_width_x,
   input  logic [rbbe_pkg::HALF_W-1:0]          req_half_height,
   input  logic [rbbe_pkg::HALF_W-1:0]          req_half_width_z,
   input  logic                                 req_has_rotation,
   input  logic signed [rbbe_pkg::QUAT_W-1:0]   req_quat_x,
   input  logic signed [rbbe_pkg::QUAT_W-1:0]   req_quat_y,
   input  logic signed [rbbe_pkg::QUAT_W-1:0]   req_quat_z,
   input  logic signed [rbbe_pkg::QUAT_W-1:0]   req_quat_w,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rbbe_pkg::EXT_W-1:0]           rsp_extent_x,
   output logic [rbbe_pkg::EXT_W-1:0]           rsp_extent_y,
   output logic [rbbe_pkg::EXT_W-1:0]           rsp_extent_z
);
   import rbbe_pkg::*;

   shape_type                    req_shape;
   shape_type                    mat_shape;
   logic                         mat_valid;
   logic                         mat_ready;
   logic [8:0][QUAT_FRAC_BITS:0] mat_mag;
   logic [2:0][EXT_W-1:0]        ext;

   assign req_shape.hx  = req_half_width_x;
   assign req_shape.hy  = req_half_height;
   assign req_shape.hz  = req_half_width_z;
   assign req_shape.rot = req_has_rotation;

   rbbe_matrix #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_shape  (req_shape),
      .in_qx     (req_quat_x),
      .in_qy     (req_quat_y),
      .in_qz     (req_quat_z),
      .in_qw     (req_quat_w),
      .out_valid (mat_valid),
      .out_ready (mat_ready),
      .out_shape (mat_shape),
      .out_mag   (mat_mag)
   );

   rbbe_extent #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_extent (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_ready  (mat_ready),
      .in_shape  (mat_shape),
      .in_mag    (mat_mag),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_ext   (ext)
   );

   assign rsp_extent_x = ext[0];
   assign rsp_extent_y = ext[1];
   assign rsp_extent_z = ext[2];

   // With the receiver taking words, every stage advances, so the input must be open.
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while the output is being drained");

   // The matrix stages must not run ahead of the extent stages by dropping a word.
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      (mat_valid && !mat_ready) |=> mat_valid)
      else $error("word lost between matrix and extent stages");

endmodule

>>> bench/tb_rotated_box_bound_extents_unit.sv
`timescale 1ns / 1ps

module tb_rotated_box_bound_extents_unit;
   import rbbe_pkg::*;

   localparam int     QF           = 14;
   localparam longint UNIT_SQ      = 64'sd1 << (2 * QF);
   localparam longint HALF_LSB     = 64'sd1 << (QF - 1);
   localparam int     RANDOM_WORDS = 1000;
   localparam int     STALL_LIMIT  = 2000;
   localparam int     TAIL_CYCLES  = 20;

   typedef struct {
      shape_type         shape;
      logic [QUAT_W-1:0] qx;
      logic [QUAT_W-1:0] qy;
      logic [QUAT_W-1:0] qz;
      logic [QUAT_W-1:0] qw;
      bit                drain_first;
   } box_word_t;

   typedef struct {
      logic [EXT_W-1:0] ex;
      logic [EXT_W-1:0] ey;
      logic [EXT_W-1:0] ez;
   } extent_set_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [HALF_W-1:0]        req_half_width_x = '0;
   logic [HALF_W-1:0]        req_half_height = '0;
   logic [HALF_W-1:0]        req_half_width_z = '0;
   logic                     req_has_rotation = 1'b0;
   logic signed [QUAT_W-1:0] req_quat_x = '0;
   logic signed [QUAT_W-1:0] req_quat_y = '0;
   logic signed [QUAT_W-1:0] req_quat_z = '0;
   logic signed [QUAT_W-1:0] req_quat_w = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [EXT_W-1:0]         rsp_extent_x;
   logic [EXT_W-1:0]         rsp_extent_y;
   logic [EXT_W-1:0]         rsp_extent_z;

   box_word_t   shape_words[$];
   extent_set_t awaited_extents[$];
   box_word_t   in_flight;
   int          total_words;
   int          accepted_words = 0;
   int          idle_phase = 0;
   int          mismatches = 0;
   int          stall_cycles = 0;

   rotated_box_bound_extents_unit #(.QUAT_FRAC_BITS(QF)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_half_width_x (req_half_width_x),
      .req_half_height  (req_half_height),
      .req_half_width_z (req_half_width_z),
      .req_has_rotation (req_has_rotation),
      .req_quat_x       (req_quat_x),
      .req_quat_y       (req_quat_y),
      .req_quat_z       (req_quat_z),
      .req_quat_w       (req_quat_w),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_extent_x     (rsp_extent_x),
      .rsp_extent_y     (rsp_extent_y),
      .rsp_extent_z     (rsp_extent_z)
   );

   always #6 clock = ~clock;

   // Magnitude of a matrix entry with 2F fraction bits, clamped to 1.0 and
   // rounded half up to F fraction bits.
   function automatic longint entry_weight(longint r);
      longint mag;
      mag = (r < 0) ? -r : r;
      if (mag > UNIT_SQ) mag = UNIT_SQ;
      return (mag + HALF_LSB) >>> QF;
   endfunction

   function automatic logic [EXT_W-1:0] row_extent(longint hx, longint hy, longint hz,
                                                   longint ra, longint rb, longint rc);
      longint sum;
      sum = hx * entry_weight(ra) + hy * entry_weight(rb) + hz * entry_weight(rc);
      sum = (sum + HALF_LSB) >>> QF;
      if (sum > EXT_MAX) sum = EXT_MAX;
      return EXT_W'(sum);
   endfunction

   function automatic extent_set_t predict_extents(box_word_t w);
      extent_set_t e;
      longint hx, hy, hz, x, y, z, s;
      longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
      hx = w.shape.hx;
      hy = w.shape.hy;
      hz = w.shape.hz;
      if (!w.shape.rot) begin
         e.ex = EXT_W'(hx);
         e.ey = EXT_W'(hy);
         e.ez = EXT_W'(hz);
         return e;
      end
      x = $signed(w.qx);
      y = $signed(w.qy);
      z = $signed(w.qz);
      s = $signed(w.qw);
      xx = x * x;  yy = y * y;  zz = z * z;
      xy = x * y;  xz = x * z;  yz = y * z;
      sx = s * x;  sy = s * y;  sz = s * z;
      e.ex = row_extent(hx, hy, hz, UNIT_SQ - 2 * (yy + zz), 2 * (xy - sz), 2 * (xz + sy));
      e.ey = row_extent(hx, hy, hz, 2 * (xy + sz), UNIT_SQ - 2 * (xx + zz), 2 * (yz - sx));
      e.ez = row_extent(hx, hy, hz, 2 * (xz - sy), 2 * (yz + sx), UNIT_SQ - 2 * (xx + yy));
      return e;
   endfunction

   function automatic box_word_t make_word(int hx, int hy, int hz, bit rot,
                                           int qx, int qy, int qz, int qw);
      box_word_t w;
      w.shape.hx    = hx[HALF_W-1:0];
      w.shape.hy    = hy[HALF_W-1:0];
      w.shape.hz    = hz[HALF_W-1:0];
      w.shape.rot   = rot;
      w.qx          = qx[QUAT_W-1:0];
      w.qy          = qy[QUAT_W-1:0];
      w.qz          = qz[QUAT_W-1:0];
      w.qw          = qw[QUAT_W-1:0];
      w.drain_first = 1'b0;
      return w;
   endfunction

   function automatic box_word_t random_word();
      int  h[3];
      int  q[4];
      real n;
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(9))
            0: h[i] = 0;
            1: h[i] = 65535;
            2: h[i] = $urandom_range(255);
            default: h[i] = $urandom_range(65535);
         endcase
      end
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: begin
            // Mostly proper rotations: a random direction scaled to unit length.
            n = 0.0;
            for (int i = 0; i < 4; i++) begin
               q[i] = $urandom_range(32768) - 16384;
               n += real'(q[i]) * real'(q[i]);
            end
            if (n < 1.0) begin
               q[3] = 16384;
            end else begin
               for (int i = 0; i < 4; i++) q[i] = $rtoi(real'(q[i]) * 16384.0 / $sqrt(n));
            end
         end
         6, 7: begin
            for (int i = 0; i < 4; i++) q[i] = $urandom_range(32768) - 16384;
         end
         8: begin
            for (int i = 0; i < 4; i++) begin
               case ($urandom_range(4))
                  0: q[i] = 0;
                  1: q[i] = 16384;
                  2: q[i] = -16384;
                  3: q[i] = 11585;
                  default: q[i] = -11585;
               endcase
            end
         end
         default: begin
            for (int i = 0; i < 4; i++) q[i] = $urandom_range(65535);
         end
      endcase
      return make_word(h[0], h[1], h[2], $urandom_range(4) != 0, q[0], q[1], q[2], q[3]);
   endfunction

   function automatic int sender_idle_pct(int phase);
      return (phase == 0) ? 12 : (phase == 1) ? 71 : 0;
   endfunction

   function automatic int receiver_idle_pct(int phase);
      return (phase == 0) ? 71 : (phase == 1) ? 12 : 0;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Driver: presents the next word when the channel is free.
   always @(posedge clock) begin
      logic taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            awaited_extents.push_back(predict_extents(in_flight));
            accepted_words++;
            if (accepted_words * 3 >= total_words * 2) idle_phase <= 2;
            else if (accepted_words * 3 >= total_words) idle_phase <= 1;
         end
         if (!req_valid || taken) begin
            if (shape_words.size() != 0
                && !(shape_words[0].drain_first && awaited_extents.size() != 0)
                && $urandom_range(99) >= sender_idle_pct(idle_phase)) begin
               in_flight = shape_words.pop_front();
               req_half_width_x <= in_flight.shape.hx;
               req_half_height  <= in_flight.shape.hy;
               req_half_width_z <= in_flight.shape.hz;
               req_has_rotation <= in_flight.shape.rot;
               req_quat_x       <= in_flight.qx;
               req_quat_y       <= in_flight.qy;
               req_quat_z       <= in_flight.qz;
               req_quat_w       <= in_flight.qw;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result word against the oldest prediction.
   always @(posedge clock) begin
      extent_set_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_extents.size() == 0) begin
               report_mismatch("unexpected result word, extent_x", rsp_extent_x, 0);
            end else begin
               want = awaited_extents.pop_front();
               if (rsp_extent_x !== want.ex) report_mismatch("extent_x", rsp_extent_x, want.ex);
               if (rsp_extent_y !== want.ey) report_mismatch("extent_y", rsp_extent_y, want.ey);
               if (rsp_extent_z !== want.ez) report_mismatch("extent_z", rsp_extent_z, want.ez);
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct(idle_phase));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int directed;
      // No rotation: the quaternion must be ignored, whatever it holds.
      shape_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0, 0));
      shape_words.push_back(make_word(65535, 65535, 65535, 0, 16384, -16384, 32767, -32768));
      shape_words.push_back(make_word(16'h1234, 16'hABCD, 16'h00FF, 0, -1, 1, 11585, 0));
      // Identity rotations, both signs of w.
      shape_words.push_back(make_word(65535, 65535, 65535, 1, 0, 0, 0, 16384));
      shape_words.push_back(make_word(16'h0180, 16'h0201, 16'h7FFF, 1, 0, 0, 0, -16384));
      // Half turns about each axis.
      shape_words.push_back(make_word(16'h0100, 16'h0200, 16'h0300, 1, 16384, 0, 0, 0));
      shape_words.push_back(make_word(16'h0100, 16'h0200, 16'h0300, 1, 0, 16384, 0, 0));
      shape_words.push_back(make_word(16'h0100, 16'h0200, 16'h0300, 1, 0, 0, -16384, 0));
      // Quarter turns about each axis.
      shape_words.push_back(make_word(16'h0400, 16'h0100, 16'h0080, 1, 0, 0, 11585, 11585));
      shape_words.push_back(make_word(16'h0400, 16'h0100, 16'h0080, 1, 11585, 0, 0, 11585));
      shape_words.push_back(make_word(16'h0400, 16'h0100, 16'h0080, 1, 0, -11585, 0, 11585));
      shape_words.push_back(make_word(65535, 0, 65535, 1, 0, 0, 11585, -11585));
      // A third of a turn about the diagonal, with the largest half sizes.
      shape_words.push_back(make_word(65535, 65535, 65535, 1, 8192, 8192, 8192, 8192));
      // Non-unit quaternions drive the entries into the clamp.
      shape_words.push_back(make_word(65535, 65535, 65535, 1, 16384, 16384, 16384, 16384));
      shape_words.push_back(make_word(65535, 65535, 65535, 1, -16384, -16384, -16384, -16384));
      shape_words.push_back(make_word(16'h8001, 16'h4000, 16'h0001, 1, 16384, 16384, 0, 0));
      // A zero quaternion leaves the matrix at identity.
      shape_words.push_back(make_word(65535, 16'h5555, 16'hAAAA, 1, 0, 0, 0, 0));
      // Components beyond plus or minus one, then a quaternion of single LSBs.
      shape_words.push_back(make_word(65535, 65535, 65535, 1, 32767, 32767, 32767, 32767));
      shape_words.push_back(make_word(65535, 65535, 65535, 1, -32768, -32768, -32768, -32768));
      shape_words.push_back(make_word(16'h00FF, 16'hFF00, 16'h0F0F, 1, 32767, -32768, 16384, -16384));
      shape_words.push_back(make_word(65535, 65535, 65535, 1, 1, -1, 1, -1));
      directed = shape_words.size();
      for (int i = 0; i < RANDOM_WORDS; i++) shape_words.push_back(random_word());
      total_words = shape_words.size();
      // The sender waits for the pipeline to empty before these words.
      shape_words[directed].drain_first = 1'b1;
      shape_words[total_words / 3].drain_first = 1'b1;
      shape_words[(2 * total_words) / 3].drain_first = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (shape_words.size() != 0 || req_valid || awaited_extents.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
